FILE: hdl/dpsp_pkg.sv
// dpsp_pkg: shared widths, codes and item types of the pedal sensor plausibility block
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package dpsp_pkg;

    // moving-average window, a power of two so the average is a shift
    localparam int WIN_LOG2 = 3;
    localparam int WINDOW   = 2 ** WIN_LOG2;

    localparam int SAMPLE_W = 10;
    localparam int LIMIT_W  = 10;
    localparam int MARGIN_W = 8;
    localparam int TRIM_W   = 8;
    localparam int DELTA_W  = 10;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int SUM_W    = SAMPLE_W + WIN_LOG2;
    localparam int SLOT_W   = WIN_LOG2;

    // percent scaling
    localparam int PCT_FULL = 100;
    localparam int PCT_W    = 7;
    localparam int SPAN_W   = 11;
    localparam int NUM_W    = 17;
    localparam int STEP_W   = $clog2(PCT_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRI_LOW   = 3'd0,
        CFG_PRI_HIGH  = 3'd1,
        CFG_SEC_LOW   = 3'd2,
        CFG_SEC_HIGH  = 3'd3,
        CFG_MARGIN    = 3'd4,
        CFG_TRIM      = 3'd5,
        CFG_DELTA_MAX = 3'd6,
        CFG_DELTA_MIN = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LANE,
        ST_DIV,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] primary_sample;
        logic [SAMPLE_W-1:0] secondary_sample;
    } sample_t;

    typedef struct packed {
        logic [PCT_W-1:0]    pedal_percent;
        logic [SAMPLE_W-1:0] primary_average;
        logic                primary_below;
        logic                primary_above;
        logic                secondary_below;
        logic                secondary_above;
        logic                delta_fault;
    } result_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]  primary_low_limit;
        logic [LIMIT_W-1:0]  primary_high_limit;
        logic [LIMIT_W-1:0]  secondary_low_limit;
        logic [LIMIT_W-1:0]  secondary_high_limit;
        logic [MARGIN_W-1:0] range_margin;
        logic [TRIM_W-1:0]   scale_trim;
        logic [DELTA_W-1:0]  delta_max;
        logic [DELTA_W-1:0]  delta_min;
    } cfg_t;

    // what one sensor lane reports to the merge stage
    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                below;
        logic                above;
    } lane_res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: hdl/dpsp_lane.sv
// dpsp_lane: one sensor lane, sample window, running sum, average and range flags
// depends on dpsp_pkg
`timescale 1ns / 1ps

module dpsp_lane
    import dpsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [SLOT_W-1:0]   slot,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [LIMIT_W-1:0]  low_limit,
    input  logic [LIMIT_W-1:0]  high_limit,
    input  logic [MARGIN_W-1:0] margin,
    output lane_res_t           res
);

    logic [SAMPLE_W-1:0] window_reg [WINDOW];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [LIMIT_W:0]    avg_plus_margin;
    logic [LIMIT_W:0]    high_plus_margin;
    logic                below;

    // oldest sample leaves the sum as the new one enters
    assign sum_next = sum_reg - SUM_W'(window_reg[slot]) + SUM_W'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            avg_reg <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (load)
        begin
            sum_reg          <= sum_next;
            avg_reg          <= sum_next[SUM_W-1:WIN_LOG2];
            window_reg[slot] <= sample;
        end
    end

    // limit minus margin compared as avg plus margin, so no wrap below zero
    assign avg_plus_margin  = {1'b0, avg_reg} + (LIMIT_W+1)'(margin);
    assign high_plus_margin = {1'b0, high_limit} + (LIMIT_W+1)'(margin);
    assign below            = avg_plus_margin < {1'b0, low_limit};

    assign res.average = avg_reg;
    assign res.below   = below;
    assign res.above   = !below && ({1'b0, avg_reg} > high_plus_margin);

endmodule

FILE: hdl/dpsp_div.sv
// dpsp_div: restoring divider for the percent quotient, one quotient bit per cycle
// depends on dpsp_pkg
`timescale 1ns / 1ps

module dpsp_div
    import dpsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [SPAN_W-1:0] span,
    output logic [PCT_W-1:0]  quotient,
    output div_stat_t         stat
);

    logic [NUM_W-1:0]  rem_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [PCT_W-1:0]  q_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [NUM_W-1:0]  shifted;
    logic              fits;

    // quotient stays below 2**PCT_W, so span shifted by the top step fits NUM_W
    assign shifted = NUM_W'(span_reg) << step_reg;
    assign fits    = rem_reg >= shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (step_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            span_reg <= span;
            q_reg    <= '0;
            step_reg <= STEP_W'(PCT_W - 1);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - shifted;
            end
            q_reg[step_reg] <= fits;
            step_reg        <= step_reg - STEP_W'(1);
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: hdl/dpsp_merge.sv
// dpsp_merge: combines both lanes into one result item, delta check and percent select
// depends on dpsp_pkg
`timescale 1ns / 1ps

module dpsp_merge
    import dpsp_pkg::*;
(
    input  lane_res_t         pri,
    input  lane_res_t         sec,
    input  cfg_t              cfg,
    input  logic [PCT_W-1:0]  quotient,
    output logic [NUM_W-1:0]  num,
    output logic [SPAN_W-1:0] span,
    output result_t           result
);

    logic [SPAN_W:0]     span_wide;
    logic [SPAN_W-1:0]   offset;
    logic [SAMPLE_W-1:0] delta;
    logic                pct_high;
    logic                pct_low;

    // span and numerator only matter when low <= avg <= high
    assign span_wide = (SPAN_W+1)'(cfg.primary_high_limit)
                     + (SPAN_W+1)'({cfg.scale_trim, 1'b0})
                     - (SPAN_W+1)'(cfg.primary_low_limit);
    assign span      = span_wide[SPAN_W-1:0];
    assign offset    = SPAN_W'(pri.average) - SPAN_W'(cfg.primary_low_limit)
                     + SPAN_W'(cfg.scale_trim);
    assign num       = NUM_W'(offset) * NUM_W'(PCT_FULL);

    assign pct_high = pri.average > cfg.primary_high_limit;
    assign pct_low  = pri.average < cfg.primary_low_limit;

    assign delta = (pri.average >= sec.average) ? (pri.average - sec.average)
                                                : (sec.average - pri.average);

    always_comb
    begin
        priority if (pct_high)
        begin
            result.pedal_percent = PCT_W'(PCT_FULL);
        end
        else if (pct_low || (span == '0))
        begin
            result.pedal_percent = '0;
        end
        else
        begin
            result.pedal_percent = quotient;
        end
        result.primary_average = pri.average;
        result.primary_below   = pri.below;
        result.primary_above   = pri.above;
        result.secondary_below = sec.below;
        result.secondary_above = sec.above;
        result.delta_fault     = (delta < cfg.delta_min) || (delta > cfg.delta_max);
    end

endmodule

FILE: hdl/dual_pedal_sensor_plausibility.sv
// dual_pedal_sensor_plausibility: top level, config registers, control and output register
// depends on dpsp_pkg, dpsp_lane, dpsp_div and dpsp_merge
`timescale 1ns / 1ps

// usage
//   sample channel: sample_valid / sample_stall with one item holding a primary and
//     a secondary pedal reading; an item is taken when valid is high and stall low
//   result channel: result_valid / result_stall with one item per sample: percent,
//     primary average, range flags of both sensors and the delta fault
//   config port: cfg_we, cfg_index, cfg_data write one limit register per edge;
//     write only while no item is in flight
//   pacing: one item at a time, the next sample is taken once the last result has
//     entered the output register; the 7-step percent divider makes one quotient
//     bit per cycle
//   stall: a waiting result sits in the output register, so the next sample is
//     taken meanwhile; only a second finished result waits until the first leaves
//   reset: windows, sums and the write slot clear to zero, limits load defaults;
//     the first WINDOW-1 averages are pulled toward zero during warm-up
module dual_pedal_sensor_plausibility
    import dpsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_t              sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t              cfg_reg;
    state_t            state_reg;
    state_t            state_next;
    logic [SLOT_W-1:0] slot_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;

    logic              lane_load;
    logic              div_start;
    logic              out_load;
    logic              out_free;
    lane_res_t         pri_res;
    lane_res_t         sec_res;
    logic [PCT_W-1:0]  quotient;
    logic [NUM_W-1:0]  num;
    logic [SPAN_W-1:0] span;
    div_stat_t         div_stat;
    result_t           merged;

    // configuration registers, defaults at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.primary_low_limit    <= LIMIT_W'(385);
            cfg_reg.primary_high_limit   <= LIMIT_W'(575);
            cfg_reg.secondary_low_limit  <= LIMIT_W'(405);
            cfg_reg.secondary_high_limit <= LIMIT_W'(600);
            cfg_reg.range_margin         <= MARGIN_W'(40);
            cfg_reg.scale_trim           <= TRIM_W'(3);
            cfg_reg.delta_max            <= DELTA_W'(30);
            cfg_reg.delta_min            <= DELTA_W'(0);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PRI_LOW:   cfg_reg.primary_low_limit    <= cfg_data;
                CFG_PRI_HIGH:  cfg_reg.primary_high_limit   <= cfg_data;
                CFG_SEC_LOW:   cfg_reg.secondary_low_limit  <= cfg_data;
                CFG_SEC_HIGH:  cfg_reg.secondary_high_limit <= cfg_data;
                CFG_MARGIN:    cfg_reg.range_margin         <= cfg_data[MARGIN_W-1:0];
                CFG_TRIM:      cfg_reg.scale_trim           <= cfg_data[TRIM_W-1:0];
                CFG_DELTA_MAX: cfg_reg.delta_max            <= cfg_data;
                CFG_DELTA_MIN: cfg_reg.delta_min            <= cfg_data;
            endcase
        end
    end

    // output register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next   = state_reg;
        sample_stall = 1'b1;
        lane_load    = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    lane_load  = 1'b1;
                    state_next = ST_LANE;
                end
            end
            ST_LANE:
            begin
                // lane averages are settled, kick off the percent divide
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                // finished result waits for the output register to empty
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (lane_load)
            begin
                // power-of-two window, slot wraps on its own
                slot_reg <= slot_reg + SLOT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= merged;
        end
    end

    // primary and secondary lanes run side by side on one item
    dpsp_lane u_lane_pri (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (lane_load),
        .slot       (slot_reg),
        .sample     (sample.primary_sample),
        .low_limit  (cfg_reg.primary_low_limit),
        .high_limit (cfg_reg.primary_high_limit),
        .margin     (cfg_reg.range_margin),
        .res        (pri_res)
    );

    dpsp_lane u_lane_sec (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (lane_load),
        .slot       (slot_reg),
        .sample     (sample.secondary_sample),
        .low_limit  (cfg_reg.secondary_low_limit),
        .high_limit (cfg_reg.secondary_high_limit),
        .margin     (cfg_reg.range_margin),
        .res        (sec_res)
    );

    dpsp_merge u_merge (
        .pri      (pri_res),
        .sec      (sec_res),
        .cfg      (cfg_reg),
        .quotient (quotient),
        .num      (num),
        .span     (span),
        .result   (merged)
    );

    dpsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num),
        .span     (span),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

FILE: hdl/dpsp_checker.sv
// dpsp_checker: port-level assertions for the pedal plausibility block, bound to the top
// depends on dpsp_pkg and dual_pedal_sensor_plausibility
`timescale 1ns / 1ps

module dpsp_checker
    import dpsp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 sample_valid,
    input logic                 sample_stall,
    input logic                 result_valid,
    input logic                 result_stall,
    input result_t              result
);

    logic sample_take;

    assign sample_take = sample_valid && !sample_stall;

    // stalled result stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // stalled result payload does not change
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    // one item at a time: after a sample is taken the port stalls
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        sample_take |=> sample_stall)
        else $error("sample taken while previous item in flight");

    // percent never leaves its range
    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.pedal_percent <= PCT_W'(PCT_FULL)))
        else $error("pedal percent above full scale");

    // a sensor is never flagged both below and above
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.primary_below && result.primary_above)
                      && !(result.secondary_below && result.secondary_above))
        else $error("below and above flagged together");

endmodule

bind dual_pedal_sensor_plausibility dpsp_checker u_dpsp_checker (.*);

FILE: sim/tb_dual_pedal_sensor_plausibility.sv
// tb_dual_pedal_sensor_plausibility: self-checking bench for the pedal sensor plausibility block
// predicts averages, range flags, delta fault and percent per item; depends on dpsp_pkg and the rtl
`timescale 1ns / 1ps

module tb_dual_pedal_sensor_plausibility;
    import dpsp_pkg::*;

    // generous cycle bound for the watchdog
    localparam int CYCLE_LIMIT  = 300000;
    localparam int CHUNK_ITEMS  = 57;
    localparam int CHUNKS       = 12;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    sample_t              sample_item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    dual_pedal_sensor_plausibility u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------

    // sensor pairs waiting to be offered, and results the block owes us
    sample_t pending_samples[$];
    result_t expected_results[$];

    // shadow of the limit registers, reset values as the block loads them
    cfg_t limits = '{
        primary_low_limit:    10'd385,
        primary_high_limit:   10'd575,
        secondary_low_limit:  10'd405,
        secondary_high_limit: 10'd600,
        range_margin:         8'd40,
        scale_trim:           8'd3,
        delta_max:            10'd30,
        delta_min:            10'd0
    };

    // shadow moving-average windows, zero filled like the block after reset
    int pri_window[WINDOW] = '{default: 0};
    int sec_window[WINDOW] = '{default: 0};
    int pri_sum   = 0;
    int sec_sum   = 0;
    int next_slot = 0;

    // 0: sender idles 38%, receiver 63%; 1: swapped; 2: no idling
    int idle_mode = 0;

    int mismatch_count     = 0;
    int accepted_items     = 0;
    int checked_results    = 0;
    int cycle_count        = 0;
    int sender_drains      = 0;
    int long_hold_requests = 0;
    int long_hold_served   = 0;
    int long_hold_left     = 0;
    bit drain_before_next  = 1'b0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // primary percent over a span widened by the trim on both ends
    function automatic logic [PCT_W-1:0] scale_percent(int avg, int lo, int hi, int trim);
        int base;
        int span;
        int num;
        if (avg > hi)
            return PCT_W'(PCT_FULL);
        if (avg < lo)
            return '0;
        base = lo - trim;
        span = (hi + trim) - base;
        num  = (avg - base) * PCT_FULL;
        // empty span: the numerator is zero anyway
        if (span <= 0)
            return '0;
        return PCT_W'(num / span);
    endfunction

    // push one sensor pair into the shadow windows and judge the new averages
    function automatic result_t predict_result(sample_t s);
        result_t r;
        int pa;
        int sa;
        int diff;
        int m;
        pri_sum = pri_sum - pri_window[next_slot] + int'(s.primary_sample);
        sec_sum = sec_sum - sec_window[next_slot] + int'(s.secondary_sample);
        pri_window[next_slot] = int'(s.primary_sample);
        sec_window[next_slot] = int'(s.secondary_sample);
        next_slot = (next_slot + 1) % WINDOW;

        pa = pri_sum / WINDOW;
        sa = sec_sum / WINDOW;
        m  = int'(limits.range_margin);

        // signed compares: a limit minus margin below zero never flags,
        // a limit plus margin above full scale never flags
        r.primary_below   = pa < int'(limits.primary_low_limit) - m;
        r.primary_above   = !r.primary_below && pa > int'(limits.primary_high_limit) + m;
        r.secondary_below = sa < int'(limits.secondary_low_limit) - m;
        r.secondary_above = !r.secondary_below
                            && sa > int'(limits.secondary_high_limit) + m;

        diff = (pa > sa) ? pa - sa : sa - pa;
        r.delta_fault = diff < int'(limits.delta_min) || diff > int'(limits.delta_max);

        r.primary_average = SAMPLE_W'(pa);
        r.pedal_percent   = scale_percent(pa, int'(limits.primary_low_limit),
                                          int'(limits.primary_high_limit),
                                          int'(limits.scale_trim));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int clamp_sample(int v);
        if (v < 0)
            return 0;
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        return v;
    endfunction

    // a reading that tends to sit on a decision edge of the given limit pair
    function automatic int near_range(int a, int b, int m);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        case ($urandom_range(0, 4))
            0:       return clamp_sample(lo - m + int'($urandom_range(0, 12)) - 6);
            1:       return clamp_sample(hi + m + int'($urandom_range(0, 12)) - 6);
            2:       return int'($urandom_range(lo, hi));
            3:       return clamp_sample(($urandom_range(0, 1) ? lo : hi)
                                         + int'($urandom_range(0, 2)) - 1);
            default: return int'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    task automatic queue_pair(input int p, input int s);
        pending_samples.push_back('{primary_sample: SAMPLE_W'(p),
                                    secondary_sample: SAMPLE_W'(s)});
    endtask

    // one register write; only called while nothing is in flight
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        // narrow registers drop the stray upper bits
        case (idx)
            CFG_PRI_LOW:   limits.primary_low_limit    = value[LIMIT_W-1:0];
            CFG_PRI_HIGH:  limits.primary_high_limit   = value[LIMIT_W-1:0];
            CFG_SEC_LOW:   limits.secondary_low_limit  = value[LIMIT_W-1:0];
            CFG_SEC_HIGH:  limits.secondary_high_limit = value[LIMIT_W-1:0];
            CFG_MARGIN:    limits.range_margin         = value[MARGIN_W-1:0];
            CFG_TRIM:      limits.scale_trim           = value[TRIM_W-1:0];
            CFG_DELTA_MAX: limits.delta_max            = value[DELTA_W-1:0];
            CFG_DELTA_MIN: limits.delta_min            = value[DELTA_W-1:0];
            default: ;
        endcase
    endtask

    // load a full set of limits: fixed corner settings, then random ones
    task automatic apply_setting(input int which);
        int lo;
        int dmax;
        case (which)
            0:
            begin
                // widest limits, no margin, no trim, every delta allowed
                write_reg(CFG_PRI_LOW,   10'd0);
                write_reg(CFG_PRI_HIGH,  10'd1023);
                write_reg(CFG_SEC_LOW,   10'd0);
                write_reg(CFG_SEC_HIGH,  10'd1023);
                write_reg(CFG_MARGIN,    10'd0);
                write_reg(CFG_TRIM,      10'd0);
                write_reg(CFG_DELTA_MAX, 10'd1023);
                write_reg(CFG_DELTA_MIN, 10'd0);
            end
            1:
            begin
                // low above high, full margin and trim with stray upper bits,
                // delta window that nothing can satisfy
                write_reg(CFG_PRI_LOW,   10'd1023);
                write_reg(CFG_PRI_HIGH,  10'd0);
                write_reg(CFG_SEC_LOW,   10'd512);
                write_reg(CFG_SEC_HIGH,  10'd512);
                write_reg(CFG_MARGIN,    10'h3FF);
                write_reg(CFG_TRIM,      10'h3FF);
                write_reg(CFG_DELTA_MAX, 10'd0);
                write_reg(CFG_DELTA_MIN, 10'd1023);
            end
            2:
            begin
                // empty scaling span: low equals high and no trim
                write_reg(CFG_PRI_LOW,   10'd300);
                write_reg(CFG_PRI_HIGH,  10'd300);
                write_reg(CFG_SEC_LOW,   10'd100);
                write_reg(CFG_SEC_HIGH,  10'd900);
                write_reg(CFG_MARGIN,    10'd5);
                write_reg(CFG_TRIM,      10'd0);
                write_reg(CFG_DELTA_MAX, 10'd50);
                write_reg(CFG_DELTA_MIN, 10'd10);
            end
            3:
            begin
                // limit minus margin under zero, limit plus margin past full scale
                write_reg(CFG_PRI_LOW,   10'd20);
                write_reg(CFG_PRI_HIGH,  10'd1010);
                write_reg(CFG_SEC_LOW,   10'd30);
                write_reg(CFG_SEC_HIGH,  10'd1000);
                write_reg(CFG_MARGIN,    10'd100);
                write_reg(CFG_TRIM,      10'd40);
                write_reg(CFG_DELTA_MAX, 10'd25);
                write_reg(CFG_DELTA_MIN, 10'd3);
            end
            default:
            begin
                lo   = int'($urandom_range(0, 700));
                dmax = int'($urandom_range(0, 200));
                write_reg(CFG_PRI_LOW,   CFG_W'(lo));
                write_reg(CFG_PRI_HIGH,  CFG_W'(lo + int'($urandom_range(0, 323))));
                lo   = int'($urandom_range(0, 700));
                write_reg(CFG_SEC_LOW,   CFG_W'(lo));
                write_reg(CFG_SEC_HIGH,  CFG_W'(lo + int'($urandom_range(0, 323))));
                write_reg(CFG_MARGIN,    CFG_W'($urandom_range(0, SAMPLE_MAX)));
                write_reg(CFG_TRIM,      CFG_W'($urandom_range(0, SAMPLE_MAX)));
                write_reg(CFG_DELTA_MAX, CFG_W'(dmax));
                write_reg(CFG_DELTA_MIN, CFG_W'($urandom_range(0, dmax)));
            end
        endcase
    endtask

    // sender pause: wait until everything queued has gone in and come back
    task automatic drain_all;
        while (pending_samples.size() != 0 || expected_results.size() != 0 || sample_valid)
            @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0d at cycle %0d: %s expected %0d got %0d",
                     mismatch_count, cycle_count, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // sample side driver
    // ------------------------------------------------------------------

    // predicts at the accepting edge, then picks what to offer next;
    // a stalled item stays put, valid is written once per edge
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        int  idle_pct;
        bit  offer;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            idle_pct = (idle_mode == 0) ? 38 : (idle_mode == 1) ? 63 : 0;
            if (sample_valid && !sample_stall)
            begin
                expected_results.push_back(predict_result(sample_item));
                accepted_items++;
                // now and then hold back until every result is home
                if ($urandom_range(0, 59) == 0)
                begin
                    drain_before_next = 1'b1;
                    sender_drains++;
                end
            end
            if (!(sample_valid && sample_stall))
            begin
                if (drain_before_next && expected_results.size() == 0)
                    drain_before_next = 1'b0;
                offer = pending_samples.size() != 0 && !drain_before_next
                        && $urandom_range(0, 99) >= idle_pct;
                if (offer)
                begin
                    sample_item  <= pending_samples.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: stall generator and checker
    // ------------------------------------------------------------------

    // random stall per mode, plus long hold-offs that back the block up
    always @(posedge clk or negedge rst_n)
    begin : result_receiver
        int idle_pct;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            idle_pct = (idle_mode == 0) ? 63 : (idle_mode == 1) ? 38 : 0;
            if (long_hold_served != long_hold_requests)
            begin
                long_hold_served++;
                long_hold_left = int'($urandom_range(60, 120));
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= $urandom_range(0, 99) < idle_pct;
            end
        end
    end

    // every accepted result against the oldest expectation, field by field
    always @(posedge clk)
    begin : result_checker
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                note_mismatch("result with nothing outstanding, primary_average",
                              -1, int'(result.primary_average));
            end
            else
            begin
                want = expected_results.pop_front();
                checked_results++;
                if (result.pedal_percent !== want.pedal_percent)
                    note_mismatch("pedal_percent", int'(want.pedal_percent),
                                  int'(result.pedal_percent));
                if (result.primary_average !== want.primary_average)
                    note_mismatch("primary_average", int'(want.primary_average),
                                  int'(result.primary_average));
                if (result.primary_below !== want.primary_below)
                    note_mismatch("primary_below", int'(want.primary_below),
                                  int'(result.primary_below));
                if (result.primary_above !== want.primary_above)
                    note_mismatch("primary_above", int'(want.primary_above),
                                  int'(result.primary_above));
                if (result.secondary_below !== want.secondary_below)
                    note_mismatch("secondary_below", int'(want.secondary_below),
                                  int'(result.secondary_below));
                if (result.secondary_above !== want.secondary_above)
                    note_mismatch("secondary_above", int'(want.secondary_above),
                                  int'(result.secondary_above));
                if (result.delta_fault !== want.delta_fault)
                    note_mismatch("delta_fault", int'(want.delta_fault),
                                  int'(result.delta_fault));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial
    begin
        int k;
        int i;
        int tp;
        int ts;
        int off;
        int p;
        int s;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed, on reset limits: warm-up from zero filled windows,
        // full scale until the windows saturate, alternating bit patterns,
        // then settling inside the limits and at the high edge
        queue_pair(0, 0);
        for (i = 0; i < WINDOW; i++)
            queue_pair(SAMPLE_MAX, SAMPLE_MAX);
        queue_pair(10'h2AA, 10'h155);
        queue_pair(10'h2AA, 10'h155);
        queue_pair(10'h155, 10'h2AA);
        queue_pair(10'h155, 10'h2AA);
        for (i = 0; i < WINDOW; i++)
            queue_pair(480, 500);
        queue_pair(575, 600);
        queue_pair(575, 600);
        drain_all();

        // random part: each chunk runs one limit setting under one idle mix
        for (k = 0; k < CHUNKS; k++)
        begin
            idle_mode = k / 4;
            apply_setting(k % 6);
            for (i = 0; i < CHUNK_ITEMS; i++)
            begin
                // slow-moving targets so the window averages reach the edges
                if (i % 12 == 0)
                begin
                    tp = near_range(int'(limits.primary_low_limit),
                                    int'(limits.primary_high_limit),
                                    int'(limits.range_margin));
                    if ($urandom_range(0, 2) == 0)
                    begin
                        ts = near_range(int'(limits.secondary_low_limit),
                                        int'(limits.secondary_high_limit),
                                        int'(limits.range_margin));
                    end
                    else
                    begin
                        // secondary offset around the delta thresholds
                        case ($urandom_range(0, 3))
                            0:       off = int'(limits.delta_max) + int'($urandom_range(0, 4)) - 2;
                            1:       off = int'(limits.delta_min) + int'($urandom_range(0, 4)) - 2;
                            2:       off = int'($urandom_range(0, limits.delta_max));
                            default: off = int'($urandom_range(0, SAMPLE_MAX));
                        endcase
                        ts = clamp_sample($urandom_range(0, 1) ? tp + off : tp - off);
                    end
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: anything on the converter range
                    p = int'($urandom_range(0, SAMPLE_MAX));
                    s = int'($urandom_range(0, SAMPLE_MAX));
                end
                else
                begin
                    p = clamp_sample(tp + int'($urandom_range(0, 6)) - 3);
                    s = clamp_sample(ts + int'($urandom_range(0, 6)) - 3);
                end
                queue_pair(p, s);
            end
            // long receiver hold-off while the sender keeps offering
            if (k % 2 == 0)
                long_hold_requests++;
            drain_all();
        end

        // tail: let any stray result show up
        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
            note_mismatch("results never delivered", 0, expected_results.size());

        $display("run: %0d sensor pairs in, %0d results checked, %0d limit settings",
                 accepted_items, checked_results, CHUNKS + 1);
        $display("run: three idle mixes, %0d long receiver hold-offs, %0d sender drains",
                 long_hold_served, sender_drains);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
